// ===== rtl/core/nsf_pkg.sv =====
// Shared types and constants for the NMEA sentence framer.
// No dependencies; imported by every module of the framer.
`timescale 1ns / 1ps

package nsf_pkg;

  // Framing phase of the back end
  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_DATA = 2'd1,
    PH_CSUM = 2'd2
  } phase_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CH_FIX_A  = 8'h41;  // 'A'

  localparam logic [39:0] ID_RESET = 40'h4750474C4C;  // "GPGLL"
  localparam int unsigned ID_CHARS = 5;

  localparam logic [3:0] FIELD_MAX = 4'd15;

  // Queue between classifier and framer
  localparam int unsigned QDEPTH = 2;

  // One classified character
  typedef struct packed {
    logic [7:0] ch;
    logic       is_dollar;
    logic       is_star;
    logic       is_lf;
    logic       is_cr;
    logic       is_comma;
    logic       is_a;
    logic       hex_ok;
    logic [3:0] hex_val;
  } sym_t;

endpackage

// ===== rtl/core/nsf_front.sv =====
// Front end: takes received characters and classifies them into sym_t.
// Depends on nsf_pkg.
`timescale 1ns / 1ps

module nsf_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_rx_byte,
  input  logic          q_full,
  output logic          q_push,
  output nsf_pkg::sym_t q_wdata
);
  import nsf_pkg::*;

  logic       hex_ok;
  logic [3:0] hex_val;

  // hex digit decode, either case
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = in_rx_byte[3:0];
    if (in_rx_byte >= 8'h30 && in_rx_byte <= 8'h39) begin
      hex_val = in_rx_byte[3:0];
    end else if ((in_rx_byte >= 8'h41 && in_rx_byte <= 8'h46) ||
                 (in_rx_byte >= 8'h61 && in_rx_byte <= 8'h66)) begin
      hex_val = in_rx_byte[3:0] + 4'd9;
    end else begin
      hex_ok  = 1'b0;
      hex_val = 4'd0;
    end
  end

  always_comb begin
    q_wdata.ch        = in_rx_byte;
    q_wdata.is_dollar = (in_rx_byte == CH_DOLLAR);
    q_wdata.is_star   = (in_rx_byte == CH_STAR);
    q_wdata.is_lf     = (in_rx_byte == CH_LF);
    q_wdata.is_cr     = (in_rx_byte == CH_CR);
    q_wdata.is_comma  = (in_rx_byte == CH_COMMA);
    q_wdata.is_a      = (in_rx_byte == CH_FIX_A);
    q_wdata.hex_ok    = hex_ok;
    q_wdata.hex_val   = hex_val;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== rtl/core/nsf_queue.sv =====
// Short FIFO of classified characters between front and back ends.
// Depends on nsf_pkg.
`timescale 1ns / 1ps

module nsf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nsf_pkg::sym_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          rvalid,
  output nsf_pkg::sym_t rdata
);
  import nsf_pkg::*;

  localparam int unsigned PTRW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNTW = $clog2(QDEPTH + 1);

  sym_t            mem_r [QDEPTH];
  logic [PTRW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;

  function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
    if (p == PTRW'(QDEPTH - 1)) begin
      return '0;
    end else begin
      return p + PTRW'(1);
    end
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign full   = (count_r == CNTW'(QDEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rvalid)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNTW'(1)))
    else $error("queue count lost a push");

endmodule

// ===== rtl/core/nsf_back.sv =====
// Back end: sentence framing state, checksum and id checks, result register.
// Depends on nsf_pkg.
`timescale 1ns / 1ps

module nsf_back #(
  parameter int unsigned MAX_LEN = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [39:0]   cfg_data,
  input  logic          q_rvalid,
  input  nsf_pkg::sym_t q_rdata,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_echo_byte,
  output logic [3:0]    out_field_index,
  output logic          out_in_sentence,
  output logic          out_sentence_end,
  output logic          out_checksum_ok,
  output logic          out_sentence_accepted,
  output logic          out_fix_active,
  output logic          out_overflow
);
  import nsf_pkg::*;

  localparam int unsigned PW = $clog2(MAX_LEN + 1);
  localparam int unsigned HIST = 7;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic        idm_r, idm_nxt;
  logic [3:0]  cc_r, cc_nxt;
  logic [39:0] sentence_id_r;
  sym_t        hist_r [HIST];

  logic        out_valid_r;
  logic [7:0]  echo_r;
  logic [3:0]  fidx_r, fidx_nxt;
  logic        insent_r, insent_nxt;
  logic        end_r, end_nxt;
  logic        ck_r, ck_nxt;
  logic        acc_r, acc_nxt;
  logic        fix_r, fix_nxt;
  logic        ovf_r, ovf_nxt;

  sym_t        c;
  logic        in_open;
  logic        len_over;
  logic [7:0]  id_byte;
  logic        id_slot;

  assign c        = q_rdata;
  assign q_pop    = q_rvalid && (!out_valid_r || out_ready);
  assign in_open  = (phase_r == PH_DATA) || (phase_r == PH_CSUM);
  assign len_over = (pos_r >= PW'(MAX_LEN));
  assign id_slot  = (pos_r >= PW'(1)) && (pos_r <= PW'(ID_CHARS));

  always_comb begin
    case (pos_r)
      PW'(1):  id_byte = sentence_id_r[39:32];
      PW'(2):  id_byte = sentence_id_r[31:24];
      PW'(3):  id_byte = sentence_id_r[23:16];
      PW'(4):  id_byte = sentence_id_r[15:8];
      default: id_byte = sentence_id_r[7:0];
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_DATA: begin
        if (len_over) begin
          phase_nxt = PH_WAIT;
        end else if (c.is_star) begin
          phase_nxt = PH_CSUM;
        end
      end
      PH_CSUM: begin
        if (len_over || c.is_lf) begin
          phase_nxt = PH_WAIT;
        end
      end
      default: begin
        phase_nxt = c.is_dollar ? PH_DATA : PH_WAIT;
      end
    endcase
  end

  // datapath and result fields
  always_comb begin
    xor_nxt    = xor_r;
    pos_nxt    = pos_r;
    idm_nxt    = idm_r;
    cc_nxt     = cc_r;
    fidx_nxt   = 4'd0;
    insent_nxt = 1'b0;
    end_nxt    = 1'b0;
    ck_nxt     = 1'b0;
    acc_nxt    = 1'b0;
    fix_nxt    = 1'b0;
    ovf_nxt    = 1'b0;
    if (!in_open) begin
      if (c.is_dollar) begin
        xor_nxt    = 8'd0;
        pos_nxt    = PW'(1);
        idm_nxt    = 1'b1;
        cc_nxt     = 4'd0;
        insent_nxt = 1'b1;
      end
    end else begin
      insent_nxt = 1'b1;
      if (len_over) begin
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + PW'(1);
        if (phase_r == PH_DATA) begin
          if (c.is_star) begin
            if (pos_r <= PW'(ID_CHARS)) begin
              idm_nxt = 1'b0;
            end
          end else begin
            xor_nxt = xor_r ^ c.ch;
            if (id_slot && (id_byte != c.ch)) begin
              idm_nxt = 1'b0;
            end
            if (c.is_comma && (cc_r != FIELD_MAX)) begin
              cc_nxt = cc_r + 4'd1;
            end
          end
        end else if (c.is_lf) begin
          end_nxt = 1'b1;
          ck_nxt  = hist_r[3].is_star && hist_r[0].is_cr &&
                    hist_r[2].hex_ok && hist_r[1].hex_ok &&
                    ({hist_r[2].hex_val, hist_r[1].hex_val} == xor_r);
          acc_nxt = ck_nxt && idm_r;
          fix_nxt = acc_nxt && hist_r[6].is_a;
        end
      end
      fidx_nxt = cc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sentence_id_r <= ID_RESET;
    end else if (cfg_we) begin
      sentence_id_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      xor_r   <= '0;
      pos_r   <= '0;
      idm_r   <= 1'b1;
      cc_r    <= '0;
      for (int i = 0; i < HIST; i++) begin
        hist_r[i] <= '0;
      end
    end else if (q_pop) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      pos_r   <= pos_nxt;
      idm_r   <= idm_nxt;
      cc_r    <= cc_nxt;
      hist_r[0] <= c;
      for (int i = 1; i < HIST; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      echo_r   <= c.ch;
      fidx_r   <= fidx_nxt;
      insent_r <= insent_nxt;
      end_r    <= end_nxt;
      ck_r     <= ck_nxt;
      acc_r    <= acc_nxt;
      fix_r    <= fix_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_echo_byte         = echo_r;
  assign out_field_index       = fidx_r;
  assign out_in_sentence       = insent_r;
  assign out_sentence_end      = end_r;
  assign out_checksum_ok       = ck_r;
  assign out_sentence_accepted = acc_r;
  assign out_fix_active        = fix_r;
  assign out_overflow          = ovf_r;

  a_accept_needs_ck: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && acc_r) |-> (ck_r && end_r))
    else $error("sentence accepted without matching checksum");

  a_fix_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fix_r) |-> acc_r)
    else $error("fix flagged on a rejected sentence");

  a_end_or_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (end_r || ovf_r)) |-> (insent_r && !(end_r && ovf_r)))
    else $error("sentence end and overflow on the same byte");

  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (end_nxt || ovf_nxt)) |=> (phase_r == PH_WAIT))
    else $error("framing still open after sentence end");

endmodule

// ===== rtl/core/nmea_sentence_framer_top.sv =====
// NMEA sentence framer top level: classifier, queue and framing back end.
// out_valid rises once an accepted character has passed the queue entry and
// then the result register; its result transaction completes when out_ready is high.
// Throughput: one character per cycle, set by the framing update, while out_ready drains results.
// A 2-entry queue lets the input keep going while a result waits to be taken.
// Reset (rst_n low, synchronous) empties the queue, drops the pending result,
// returns framing to waiting for '$' and restores the id to "GPGLL".
`timescale 1ns / 1ps

module nmea_sentence_framer_top #(
  parameter int unsigned MAX_LEN = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: five id characters, first in bits 39..32
  input  logic        cfg_we,
  input  logic [39:0] cfg_data,
  // received characters
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // tagged echo of every character
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_echo_byte,
  output logic [3:0]  out_field_index,
  output logic        out_in_sentence,
  output logic        out_sentence_end,
  output logic        out_checksum_ok,
  output logic        out_sentence_accepted,
  output logic        out_fix_active,
  output logic        out_overflow
);
  import nsf_pkg::*;

  // front to queue
  logic q_full;
  logic q_push;
  sym_t q_wdata;

  // queue to back
  logic q_pop;
  logic q_rvalid;
  sym_t q_rdata;

  // Front end: a transaction is taken whenever the queue has room; the
  // character is decoded once here (delimiters, hex digit, status 'A').
  nsf_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // Queue decouples input acceptance from output back-pressure.
  nsf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_rvalid),
    .rdata  (q_rdata)
  );

  // Back end: framing phase, running XOR, id compare and the result register.
  // It pops one character per cycle while the result register is free or
  // being drained.
  nsf_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_data              (cfg_data),
    .q_rvalid              (q_rvalid),
    .q_rdata               (q_rdata),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_echo_byte         (out_echo_byte),
    .out_field_index       (out_field_index),
    .out_in_sentence       (out_in_sentence),
    .out_sentence_end      (out_sentence_end),
    .out_checksum_ok       (out_checksum_ok),
    .out_sentence_accepted (out_sentence_accepted),
    .out_fix_active        (out_fix_active),
    .out_overflow          (out_overflow)
  );

endmodule
